// ===== hdl/thm_pkg.sv =====
package thm_pkg;

   // Opcodes of the request word
   localparam logic [1:0] OP_WARMUP  = 2'd0;
   localparam logic [1:0] OP_OPERATE = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   // Register indexes of the configuration port
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RUN_CUTOFF  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WARMUP      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROP_CUTOFF = 2'd2;
   localparam int unsigned CSR_DATA_W = 11;

   localparam int unsigned RUN_W  = 11;
   localparam int unsigned WARM_W = 8;
   localparam int unsigned CUT_W  = 11;
   localparam int unsigned CNT_W  = 6;   // 0..32 bits of one word

   localparam logic [RUN_W-1:0]  RUN_MAX            = 11'd2047;
   localparam logic [RUN_W-1:0]  RUN_CUTOFF_RST     = 11'd64;
   localparam logic [WARM_W-1:0] WARMUP_WORDS_RST   = 8'd4;
   localparam logic [CUT_W-1:0]  PROP_CUTOFF_RST    = 11'd640;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] noise_word;
   } req_type;

   typedef struct packed {
      logic [31:0] word_out;
      logic        not_ready;
      logic        zero_run_fail;
      logic        one_run_fail;
      logic        proportion_fail;
   } rsp_type;

   // Ones count by pairwise folding
   function automatic logic [CNT_W-1:0] ones_count(input logic [31:0] w);
      logic [31:0] v;
      v = w - ((w >> 1) & 32'h5555_5555);
      v = (v & 32'h3333_3333) + ((v >> 2) & 32'h3333_3333);
      v = (v + (v >> 4)) & 32'h0F0F_0F0F;
      v = v + (v >> 8);
      v = v + (v >> 16);
      return v[CNT_W-1:0];
   endfunction

   // Zeros above the highest set bit; 32 for a zero word
   function automatic logic [CNT_W-1:0] lead_zeros(input logic [31:0] w);
      logic [CNT_W-1:0] n;
      n = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (w[i]) n = CNT_W'(31 - i);
      end
      return n;
   endfunction

   // Zeros below the lowest set bit; 32 for a zero word
   function automatic logic [CNT_W-1:0] trail_zeros(input logic [31:0] w);
      logic [CNT_W-1:0] n;
      n = 6'd32;
      for (int i = 31; i >= 0; i--) begin
         if (w[i]) n = CNT_W'(i);
      end
      return n;
   endfunction

endpackage

// ===== hdl/thm_ram.sv =====
module thm_ram #(
   parameter int unsigned WIDTH = 6,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/trng_health_monitor_unit.sv =====
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    thm_pkg::req_type (opcode, noise_word)
// rsp_      out        rsp_valid/stall    thm_pkg::rsp_type (word, flags)
// csr_      in         csr_valid/ready    csr_index, csr_wdata (always ready)
//
// One word per cycle while the result side does not stall; a result is offered after its word
// passes the issue register with ring read, then the output register after the tests.
// The ones-count ring sits in a RAM with registered read; an entry is only revisited
// WINDOW_WORDS samples later, so its read and write never collide.
// Reset is synchronous; per-entry valid bits make unwritten ring entries read as zero.
// A stalled result holds the test stage, which in turn stalls the request side.
module trng_health_monitor_unit #(
   parameter int unsigned WINDOW_WORDS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  thm_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output thm_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [thm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [thm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int unsigned PTR_W       = $clog2(WINDOW_WORDS);
   localparam int unsigned WINDOW_BITS = WINDOW_WORDS * 32;
   localparam int unsigned SUM_W       = $clog2(WINDOW_BITS + 1);
   localparam int unsigned CMP_W       = (SUM_W > thm_pkg::CUT_W ? SUM_W : thm_pkg::CUT_W) + 1;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(WINDOW_WORDS - 1);
   localparam logic [CMP_W-1:0] WIN_BITS = CMP_W'(WINDOW_BITS);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [thm_pkg::RUN_W-1:0]  run_cutoff_ff;
   logic [thm_pkg::WARM_W-1:0] warmup_words_ff;
   logic [thm_pkg::CUT_W-1:0]  prop_cutoff_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_cutoff_ff   <= thm_pkg::RUN_CUTOFF_RST;
         warmup_words_ff <= thm_pkg::WARMUP_WORDS_RST;
         prop_cutoff_ff  <= thm_pkg::PROP_CUTOFF_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            thm_pkg::CSR_RUN_CUTOFF:  run_cutoff_ff   <= csr_wdata[thm_pkg::RUN_W-1:0];
            thm_pkg::CSR_WARMUP:      warmup_words_ff <= csr_wdata[thm_pkg::WARM_W-1:0];
            thm_pkg::CSR_PROP_CUTOFF: prop_cutoff_ff  <= csr_wdata[thm_pkg::CUT_W-1:0];
            default: ;  // writes beyond the register list are dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Handshake and pipeline occupancy
   // ---------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic accept, s1_move, is_sample_in;

   assign s1_move   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;
   assign is_sample_in = (req_data.opcode == thm_pkg::OP_WARMUP) ||
                         (req_data.opcode == thm_pkg::OP_OPERATE);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept)       s1_valid_in = 1'b1;
      else if (s1_move) s1_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (s1_move)        out_valid_in = 1'b1;
      else if (!rsp_stall) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // ---------------------------------------------------------------
   // Issue stage: bit counts of the word, ring pointer, ring read
   // ---------------------------------------------------------------
   logic [PTR_W-1:0]        ptr_ff, ptr_in;
   logic [WINDOW_WORDS-1:0] entry_valid_ff, entry_valid_in;

   logic [1:0]                s1_op_ff;
   logic [31:0]               s1_word_ff;
   logic [thm_pkg::CNT_W-1:0] s1_tz0_ff, s1_tz1_ff, s1_lz0_ff, s1_lz1_ff, s1_pop_ff;
   logic [PTR_W-1:0]          s1_ptr_ff;
   logic                      s1_wrap_ff, s1_old_ok_ff;

   // Advance the pointer only for samples; restart leaves the ring alone
   always_comb begin
      ptr_in = ptr_ff;
      if (accept && is_sample_in) begin
         ptr_in = (ptr_ff == LAST_PTR) ? '0 : ptr_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) ptr_ff <= '0;
      else       ptr_ff <= ptr_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff     <= req_data.opcode;
         s1_word_ff   <= req_data.noise_word;
         s1_tz0_ff    <= thm_pkg::trail_zeros(req_data.noise_word);
         s1_tz1_ff    <= thm_pkg::trail_zeros(~req_data.noise_word);
         s1_lz0_ff    <= thm_pkg::lead_zeros(req_data.noise_word);
         s1_lz1_ff    <= thm_pkg::lead_zeros(~req_data.noise_word);
         s1_pop_ff    <= thm_pkg::ones_count(req_data.noise_word);
         s1_ptr_ff    <= ptr_ff;
         s1_wrap_ff   <= (ptr_ff == LAST_PTR);
         s1_old_ok_ff <= entry_valid_ff[ptr_ff];
      end
   end

   // ---------------------------------------------------------------
   // Ones-count ring
   // ---------------------------------------------------------------
   logic [thm_pkg::CNT_W-1:0] ring_rd_data;
   logic                      ring_wr;
   logic                      s1_sample;

   assign s1_sample = (s1_op_ff == thm_pkg::OP_WARMUP) || (s1_op_ff == thm_pkg::OP_OPERATE);
   assign ring_wr   = s1_move && s1_sample;

   thm_ram #(
      .WIDTH (thm_pkg::CNT_W),
      .DEPTH (WINDOW_WORDS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr),
      .wr_addr (s1_ptr_ff),
      .wr_data (s1_pop_ff),
      .rd_en   (accept),
      .rd_addr (ptr_ff),
      .rd_data (ring_rd_data)
   );

   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (ring_wr) entry_valid_in[s1_ptr_ff] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) entry_valid_ff <= '0;
      else       entry_valid_ff <= entry_valid_in;
   end

   // ---------------------------------------------------------------
   // Test stage: run tests, window sum, flags
   // ---------------------------------------------------------------
   logic [thm_pkg::RUN_W-1:0]  zero_run_ff, zero_run_in;
   logic [thm_pkg::RUN_W-1:0]  one_run_ff, one_run_in;
   logic [thm_pkg::WARM_W-1:0] warm_seen_ff, warm_seen_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic                       full_ff, full_in;

   logic [thm_pkg::CNT_W-1:0]  ring_old;
   logic [thm_pkg::RUN_W:0]    zero_total, one_total, zero_grow, one_grow;
   logic [CMP_W-1:0]           sum_ext, cut_ext, low_bound;
   logic                       warm_short;
   thm_pkg::rsp_type           rsp_in;
   thm_pkg::rsp_type           rsp_ff;

   assign ring_old   = s1_old_ok_ff ? ring_rd_data : '0;
   assign warm_short = warm_seen_ff < warmup_words_ff;

   always_comb begin
      zero_run_in  = zero_run_ff;
      one_run_in   = one_run_ff;
      warm_seen_in = warm_seen_ff;
      sum_in       = sum_ff;
      full_in      = full_ff;
      rsp_in       = '0;

      // Trailing run of the new word continues the open run of the last one
      zero_total = (thm_pkg::RUN_W+1)'(s1_tz0_ff) + (thm_pkg::RUN_W+1)'(zero_run_ff);
      one_total  = (thm_pkg::RUN_W+1)'(s1_tz1_ff) + (thm_pkg::RUN_W+1)'(one_run_ff);
      // A whole word of one value extends the open run, otherwise restart it
      zero_grow  = (thm_pkg::RUN_W+1)'(s1_lz0_ff) +
                   ((s1_lz0_ff == 6'd32) ? (thm_pkg::RUN_W+1)'(zero_run_ff) : '0);
      one_grow   = (thm_pkg::RUN_W+1)'(s1_lz1_ff) +
                   ((s1_lz1_ff == 6'd32) ? (thm_pkg::RUN_W+1)'(one_run_ff) : '0);

      sum_in  = sum_ff - SUM_W'(ring_old) + SUM_W'(s1_pop_ff);
      sum_ext = CMP_W'(sum_in);
      cut_ext = CMP_W'(prop_cutoff_ff);
      low_bound = (WIN_BITS > cut_ext) ? WIN_BITS - cut_ext : '0;

      case (s1_op_ff) inside
         thm_pkg::OP_WARMUP, thm_pkg::OP_OPERATE: begin
            rsp_in.word_out      = s1_word_ff;
            rsp_in.not_ready     = (s1_op_ff == thm_pkg::OP_OPERATE) &&
                                   (warm_short || !full_ff);
            rsp_in.zero_run_fail = zero_total >= (thm_pkg::RUN_W+1)'(run_cutoff_ff);
            rsp_in.one_run_fail  = one_total  >= (thm_pkg::RUN_W+1)'(run_cutoff_ff);

            zero_run_in = (zero_grow > (thm_pkg::RUN_W+1)'(thm_pkg::RUN_MAX)) ?
                          thm_pkg::RUN_MAX : zero_grow[thm_pkg::RUN_W-1:0];
            one_run_in  = (one_grow > (thm_pkg::RUN_W+1)'(thm_pkg::RUN_MAX)) ?
                          thm_pkg::RUN_MAX : one_grow[thm_pkg::RUN_W-1:0];
            if (warm_short) warm_seen_in = warm_seen_ff + thm_pkg::WARM_W'(1);

            full_in = full_ff || s1_wrap_ff;
            rsp_in.proportion_fail = full_in && ((sum_ext > cut_ext) || (sum_ext < low_bound));
         end
         thm_pkg::OP_RESTART: begin
            sum_in       = sum_ff;
            warm_seen_in = '0;
            full_in      = 1'b0;
         end
         default: begin
            sum_in = sum_ff;   // unused opcode: hold everything
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_run_ff  <= '0;
         one_run_ff   <= '0;
         warm_seen_ff <= '0;
         sum_ff       <= '0;
         full_ff      <= 1'b0;
      end else if (s1_move) begin
         zero_run_ff  <= zero_run_in;
         one_run_ff   <= one_run_in;
         warm_seen_ff <= warm_seen_in;
         sum_ff       <= sum_in;
         full_ff      <= full_in;
      end
   end

   // ---------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (s1_move) rsp_ff <= rsp_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sim/tb_trng_health_monitor_unit.sv =====
module tb_trng_health_monitor_unit;

   // Opcode 3 has no name in the package; the block must treat it as a no-op
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // Latency margin used in the drain waits below
   localparam int PIPE_LATENCY = 1;
   localparam int RING_DEPTH = 32;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_valid = 1'b0;
   logic                            req_stall;
   thm_pkg::req_type                req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   thm_pkg::rsp_type                rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [thm_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [thm_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   trng_health_monitor_unit #(.WINDOW_WORDS(RING_DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Words waiting to be offered, and results predicted for accepted words
   thm_pkg::req_type pending_words[$];
   thm_pkg::rsp_type predicted_rsp[$];

   // Traffic shaping, changed only on the falling edge
   int   sender_idle = 0;
   int   receiver_stall = 0;
   logic hold_req = 1'b0;
   int   error_count = 0;

   // Register copies as the block should hold them
   logic [thm_pkg::RUN_W-1:0]  run_cutoff_q = thm_pkg::RUN_CUTOFF_RST;
   logic [thm_pkg::WARM_W-1:0] warmup_q = thm_pkg::WARMUP_WORDS_RST;
   logic [thm_pkg::CUT_W-1:0]  prop_cutoff_q = thm_pkg::PROP_CUTOFF_RST;

   // Health state as the block should hold it
   logic [thm_pkg::RUN_W-1:0]  zero_run_len = '0;
   logic [thm_pkg::RUN_W-1:0]  one_run_len = '0;
   logic [thm_pkg::WARM_W-1:0] words_seen = '0;
   logic [thm_pkg::CNT_W-1:0]  pop_ring [RING_DEPTH];
   logic [thm_pkg::CUT_W-1:0]  pop_total = '0;
   logic [4:0]                 pop_slot = '0;
   logic                       ring_filled = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Count zeros from bit 31 downwards, 32 for a zero word
   function automatic int zeros_at_top(logic [31:0] w);
      int n;
      n = 0;
      while (n < 32 && !w[31-n]) n++;
      return n;
   endfunction

   // Count zeros from bit 0 upwards, 32 for a zero word
   function automatic int zeros_at_bottom(logic [31:0] w);
      int n;
      n = 0;
      while (n < 32 && !w[n]) n++;
      return n;
   endfunction

   function automatic logic [thm_pkg::RUN_W-1:0] capped_run(int v);
      return (v > int'(thm_pkg::RUN_MAX)) ? thm_pkg::RUN_MAX : thm_pkg::RUN_W'(v);
   endfunction

   // Advance the health state by one accepted word and return its result
   function automatic thm_pkg::rsp_type health_predict(thm_pkg::req_type item);
      thm_pkg::rsp_type want;
      logic [31:0]      w;
      int               pop;
      int               window_bits;
      int               floor_bound;
      want = '0;
      // Restart: clear warm-up and window-full only, keep runs and the ring
      if (item.opcode == thm_pkg::OP_RESTART) begin
         words_seen = '0;
         ring_filled = 1'b0;
         return want;
      end
      if (item.opcode == OP_UNUSED) return want;
      w = item.noise_word;
      // An operational word that is not ready is still tested below
      if (item.opcode == thm_pkg::OP_OPERATE)
         want.not_ready = (words_seen < warmup_q) || !ring_filled;
      // Repetition test: the bottom run continues the open run of the last word
      want.zero_run_fail = (zeros_at_bottom(w) + int'(zero_run_len)) >= int'(run_cutoff_q);
      want.one_run_fail  = (zeros_at_bottom(~w) + int'(one_run_len)) >= int'(run_cutoff_q);
      // A constant word extends the open run by the whole 32 bits
      zero_run_len = capped_run(zeros_at_top(w) + ((w == 32'h0) ? int'(zero_run_len) : 0));
      one_run_len  = capped_run(zeros_at_top(~w) + ((~w == 32'h0) ? int'(one_run_len) : 0));
      if (words_seen < warmup_q) words_seen = words_seen + 1'b1;
      // Proportion test over the ring of per-word ones counts
      pop = $countones(w);
      pop_total = pop_total - pop_ring[pop_slot] + thm_pkg::CUT_W'(pop);
      pop_ring[pop_slot] = thm_pkg::CNT_W'(pop);
      if (pop_slot == 5'(RING_DEPTH - 1)) ring_filled = 1'b1;
      pop_slot = pop_slot + 1'b1;
      window_bits = RING_DEPTH * 32;
      // A cutoff of the window size or more leaves no lower bound
      floor_bound = (window_bits > int'(prop_cutoff_q)) ? window_bits - int'(prop_cutoff_q) : 0;
      want.proportion_fail = ring_filled &&
                             (int'(pop_total) > int'(prop_cutoff_q) ||
                              int'(pop_total) < floor_bound);
      want.word_out = w;
      return want;
   endfunction

   // Driver: hold a stalled word, otherwise offer the next one or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // A word moves on this edge: predict its result now
         if (req_valid && !req_stall) predicted_rsp.push_back(health_predict(req_data));
         if (!req_valid || !req_stall) begin
            if (!hold_req && pending_words.size() != 0 &&
                $urandom_range(99) >= sender_idle) begin
               req_valid <= 1'b1;
               req_data  <= pending_words.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
         error_count++;
      end
   endtask

   // Monitor: compare each accepted result with the oldest prediction
   always @(posedge clock) begin : result_monitor
      thm_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsp.size() == 0) begin
               $display("%0t: result with none expected, expected none, actual %h",
                        $time, rsp_data);
               error_count++;
            end else begin
               want = predicted_rsp.pop_front();
               check_field("word_out", want.word_out, rsp_data.word_out);
               check_field("not_ready", want.not_ready, rsp_data.not_ready);
               check_field("zero_run_fail", want.zero_run_fail, rsp_data.zero_run_fail);
               check_field("one_run_fail", want.one_run_fail, rsp_data.one_run_fail);
               check_field("proportion_fail", want.proportion_fail,
                           rsp_data.proportion_fail);
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_stall);
      end
   end

   // Write one register and mirror it once the write has gone through
   task automatic csr_write(logic [thm_pkg::CSR_INDEX_W-1:0] idx, int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= thm_pkg::CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         thm_pkg::CSR_RUN_CUTOFF:  run_cutoff_q = thm_pkg::RUN_W'(value);
         thm_pkg::CSR_WARMUP:      warmup_q = thm_pkg::WARM_W'(value);
         thm_pkg::CSR_PROP_CUTOFF: prop_cutoff_q = thm_pkg::CUT_W'(value);
         default: begin end
      endcase
   endtask

   task automatic write_config(int run_cut, int warm, int prop_cut);
      csr_write(thm_pkg::CSR_RUN_CUTOFF, run_cut);
      csr_write(thm_pkg::CSR_WARMUP, warm);
      csr_write(thm_pkg::CSR_PROP_CUTOFF, prop_cut);
   endtask

   function automatic void push_word(logic [1:0] op, logic [31:0] w);
      thm_pkg::req_type item;
      item.opcode = op;
      item.noise_word = w;
      pending_words.push_back(item);
   endfunction

   // Mostly samples, a few restarts and the odd unused opcode
   function automatic logic [1:0] pick_opcode();
      int roll;
      roll = $urandom_range(99);
      if (roll < 2) return thm_pkg::OP_RESTART;
      if (roll < 3) return OP_UNUSED;
      if (roll < 40) return thm_pkg::OP_WARMUP;
      return thm_pkg::OP_OPERATE;
   endfunction

   // Shape noise so that runs and ones counts reach the cutoffs
   function automatic logic [31:0] shaped_word(int kind, logic level);
      logic [31:0] w;
      logic [31:0] lo_mask;
      logic [31:0] hi_mask;
      int          lo_len;
      int          hi_len;
      w = $urandom;
      case (kind)
         0: w = {32{level}};
         2: begin
            // Force runs at both ends so they join across word boundaries
            lo_len  = $urandom_range(0, 31);
            hi_len  = $urandom_range(0, 31);
            lo_mask = (lo_len == 0) ? 32'h0 : (32'hFFFF_FFFF >> (32 - lo_len));
            hi_mask = (hi_len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - hi_len));
            w = level ? (w | lo_mask) : (w & ~lo_mask);
            w = $urandom_range(1) ? (w | hi_mask) : (w & ~hi_mask);
         end
         3: w = w & $urandom & $urandom;
         4: w = w | $urandom | $urandom;
         default: begin end
      endcase
      return w;
   endfunction

   // Queue bursts of alike words; ignored words do not count
   task automatic queue_random(int count);
      int               left;
      int               kind;
      int               len;
      logic             level;
      thm_pkg::req_type item;
      @(negedge clock);
      left = count;
      while (left > 0) begin
         kind  = $urandom_range(4);
         level = $urandom_range(1);
         // Now and then a long constant burst to saturate the run counters
         len = (kind == 0 && $urandom_range(7) == 0) ? $urandom_range(32, 72)
                                                     : $urandom_range(1, 12);
         while (len > 0) begin
            item.opcode     = pick_opcode();
            item.noise_word = shaped_word(kind, level);
            pending_words.push_back(item);
            if (item.opcode != OP_UNUSED) left--;
            len--;
         end
      end
   endtask

   task automatic queue_directed();
      @(negedge clock);
      // Operational word straight after reset: nothing seen yet
      push_word(thm_pkg::OP_OPERATE, 32'h0000_0000);
      // Zero words: the open zero run grows by whole words to the cutoff
      push_word(thm_pkg::OP_WARMUP, 32'h0000_0000);
      push_word(thm_pkg::OP_WARMUP, 32'h0000_0000);
      // Ones words: same for the one run
      push_word(thm_pkg::OP_WARMUP, 32'hFFFF_FFFF);
      push_word(thm_pkg::OP_WARMUP, 32'hFFFF_FFFF);
      push_word(thm_pkg::OP_OPERATE, 32'hFFFF_FFFF);
      // Single bits at the edges break and restart the runs
      push_word(thm_pkg::OP_WARMUP, 32'h8000_0000);
      push_word(thm_pkg::OP_WARMUP, 32'h0000_0001);
      push_word(thm_pkg::OP_WARMUP, 32'h7FFF_FFFF);
      push_word(thm_pkg::OP_WARMUP, 32'hFFFF_FFFE);
      push_word(thm_pkg::OP_OPERATE, 32'hAAAA_AAAA);
      push_word(thm_pkg::OP_OPERATE, 32'h5555_5555);
      // Unused opcode: no state change, all-zero result
      push_word(OP_UNUSED, 32'h1234_5678);
      push_word(OP_UNUSED, 32'hFFFF_FFFF);
      // Restart: all-zero result, warm-up and window mark cleared
      push_word(thm_pkg::OP_RESTART, $urandom);
      push_word(thm_pkg::OP_OPERATE, $urandom);
      push_word(thm_pkg::OP_RESTART, 32'h0000_0000);
      repeat (8) push_word($urandom_range(1) ? thm_pkg::OP_OPERATE : thm_pkg::OP_WARMUP,
                           $urandom);
   endtask

   // Release the queued words under the given idling and wait for them all
   task automatic run_phase(int send_pct, int recv_pct, bit pause);
      int half;
      @(negedge clock);
      sender_idle    = send_pct;
      receiver_stall = recv_pct;
      if (pause) begin
         // Hold the sender halfway until every predicted result has come back
         half = pending_words.size() / 2;
         while (pending_words.size() > half) @(negedge clock);
         hold_req = 1'b1;
         while (req_valid || predicted_rsp.size() != 0) @(negedge clock);
         hold_req = 1'b0;
      end
      while (pending_words.size() != 0 || req_valid || predicted_rsp.size() != 0)
         @(negedge clock);
      // Let the pipeline empty before any register write
      repeat (PIPE_LATENCY + 2) @(negedge clock);
   endtask

   initial begin : stimulus
      int ph;
      int send_pct;
      int recv_pct;
      foreach (pop_ring[i]) pop_ring[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed words run under the reset values of the registers
      queue_directed();
      run_phase(0, 0, 1'b0);

      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: write_config(32, 1, 1024);
            1: write_config(1024, 255, 0);
            // Lowered warm-up after a long one; back to reset values
            2: write_config(int'(thm_pkg::RUN_CUTOFF_RST), int'(thm_pkg::WARMUP_WORDS_RST),
                            int'(thm_pkg::PROP_CUTOFF_RST));
            6: write_config(32, 255, 512);
            default: write_config($urandom_range(32, 1024), $urandom_range(1, 60),
                                  $urandom_range(0, 1024));
         endcase
         // Cycle through: no idling, sender idle, receiver stalling, both a little
         send_pct = (ph % 4 == 1) ? 80 : (ph % 4 == 3) ? 10 : 0;
         recv_pct = (ph % 4 == 2) ? 80 : (ph % 4 == 3) ? 10 : 0;
         queue_random(50);
         run_phase(send_pct, recv_pct, (ph % 2) == 0);
      end

      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_trng_health_monitor_unit: PASS");
      end else begin
         $display("tb_trng_health_monitor_unit: FAIL");
      end
      $finish;
   end

   // Give up on a hung run
   initial begin
      #2_000_000;
      $display("tb_trng_health_monitor_unit: FAIL");
      $finish;
   end

endmodule
